// File: src/byte_ring_buffer_macros.svh
// Assertion macros used by the checker file of the byte ring buffer.
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Widths, operation codes and the front-to-back command record of the byte
// ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 17;
  localparam int IDX_W  = 16;

  localparam int BRB_CAPACITY    = 65536;
  localparam int BRB_QUEUE_DEPTH = 4;

  localparam logic [CNT_W-1:0] CALL_MAX = 17'd65536;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DISCARD = 2'd3
  } brb_op_t;

  // One classified transaction: memory action plus the state after it.
  typedef struct packed {
    logic              mem_we;
    logic              rd_sel;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
    logic              ok;
    logic              became_full;
    logic              left_full;
    logic [CNT_W-1:0]  call_accepted;
    logic [IDX_W-1:0]  rd_index;
    logic [IDX_W-1:0]  wr_index;
    logic [CNT_W-1:0]  count;
  } brb_cmd_t;

endpackage

// File: src/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer: byte FIFO ring with write, pop, peek and discard.
// Result passes through the queue and then the output register.
// Throughput: one transaction per cycle while in_ready; single memory port.
// Reset clears indices, fill, call count, queue and output valid; no clear pass.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
  parameter int CAPACITY    = brb_pkg::BRB_CAPACITY,
  parameter int QUEUE_DEPTH = brb_pkg::BRB_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [brb_pkg::OP_W-1:0]   op,
  input  logic [brb_pkg::DATA_W-1:0] data,
  input  logic [brb_pkg::CNT_W-1:0]  amount,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brb_pkg::DATA_W-1:0] read_byte,
  output logic                       ok,
  output logic [brb_pkg::CNT_W-1:0]  fill,
  output logic [brb_pkg::CNT_W-1:0]  write_span,
  output logic [brb_pkg::CNT_W-1:0]  read_span,
  output logic                       became_full,
  output logic                       left_full,
  output logic [brb_pkg::CNT_W-1:0]  call_accepted
);
  import brb_pkg::*;

  // Front side: classify the transaction and advance the ring state at once,
  // so back-to-back transactions see the updated indices and fill.
  brb_cmd_t cmd;
  logic     push;
  logic     q_full;

  // Back side: head of the queue, taken when the output register frees up.
  brb_cmd_t head;
  logic     head_valid;
  logic     pop;

  brb_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .data     (data),
    .amount   (amount),
    .last     (last),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd)
  );

  // Decouple the two sides: the front keeps accepting while a result stalls.
  brb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Memory writes and reads run in queue order, so a peek or pop always
  // sees every write accepted ahead of it.
  brb_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_byte     (read_byte),
    .ok            (ok),
    .fill          (fill),
    .write_span    (write_span),
    .read_span     (read_span),
    .became_full   (became_full),
    .left_full     (left_full),
    .call_accepted (call_accepted)
  );

endmodule

// File: src/brb_front.sv
// ----------------------------------------------------------------------------
// brb_front
// Accepts transactions, updates indices, fill and call count, and issues one
// command record per transaction into the queue.
// ----------------------------------------------------------------------------
module brb_front #(
  parameter int CAPACITY = brb_pkg::BRB_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [brb_pkg::OP_W-1:0]   op,
  input  logic [brb_pkg::DATA_W-1:0] data,
  input  logic [brb_pkg::CNT_W-1:0]  amount,
  input  logic                     last,
  input  logic                     q_full,
  output logic                     push,
  output brb_pkg::brb_cmd_t        cmd
);
  import brb_pkg::*;

  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [IW-1:0]    rd_index, rd_index_next;
  logic [IW-1:0]    wr_index, wr_index_next;
  logic [CW-1:0]    count, count_next;
  logic [CNT_W-1:0] call_count, call_count_next;

  logic             at_capacity;
  logic [CNT_W-1:0] count_x;
  logic [SUM_W-1:0] ring_sum;
  logic [SUM_W-1:0] ring_wrap;
  logic [IW-1:0]    ring_idx;
  logic [IW-1:0]    wr_inc;
  logic [IW-1:0]    rd_inc;
  logic [CNT_W-1:0] call_inc;
  logic [IW-1:0]    addr;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign at_capacity = (count == CW'(CAPACITY));
  assign count_x     = CNT_W'(count);
  assign ring_sum    = SUM_W'(rd_index) + SUM_W'(amount);
  assign ring_wrap = (ring_sum >= SUM_W'(CAPACITY)) ? ring_sum - SUM_W'(CAPACITY) : ring_sum;
  assign ring_idx  = ring_wrap[IW-1:0];
  assign wr_inc    = (wr_index == IW'(CAPACITY - 1)) ? '0 : wr_index + IW'(1);
  assign rd_inc    = (rd_index == IW'(CAPACITY - 1)) ? '0 : rd_index + IW'(1);

  always_comb begin
    rd_index_next   = rd_index;
    wr_index_next   = wr_index;
    count_next      = count;
    call_count_next = call_count;
    call_inc        = call_count;
    addr            = rd_index;
    cmd             = '0;
    cmd.wdata       = data;
    case (brb_op_t'(op))
      OP_WRITE: begin
        addr = wr_index;
        if (!at_capacity) begin
          cmd.mem_we       = 1'b1;
          cmd.ok           = 1'b1;
          cmd.became_full  = (count == CW'(CAPACITY - 1));
          wr_index_next    = wr_inc;
          count_next       = count + CW'(1);
          if (call_count < CALL_MAX) begin
            call_inc = call_count + CNT_W'(1);
          end
        end
        call_count_next = last ? '0 : call_inc;
      end
      OP_POP: begin
        if (count != '0) begin
          cmd.ok        = 1'b1;
          cmd.rd_sel    = 1'b1;
          cmd.left_full = at_capacity;
          rd_index_next = rd_inc;
          count_next    = count - CW'(1);
        end
      end
      OP_PEEK: begin
        addr = ring_idx;
        if (amount < count_x) begin
          cmd.ok     = 1'b1;
          cmd.rd_sel = 1'b1;
        end
      end
      OP_DISCARD: begin
        if (amount <= count_x) begin
          cmd.ok = 1'b1;
          if (amount != '0) begin
            cmd.left_full = at_capacity;
            rd_index_next = ring_idx;
            count_next    = count - amount[CW-1:0];
          end
        end
      end
      default: begin
        cmd.ok = 1'b0;
      end
    endcase
    cmd.addr          = IDX_W'(addr);
    cmd.call_accepted = call_inc;
    cmd.rd_index      = IDX_W'(rd_index_next);
    cmd.wr_index      = IDX_W'(wr_index_next);
    cmd.count         = CNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_index   <= '0;
      wr_index   <= '0;
      count      <= '0;
      call_count <= '0;
    end else if (push) begin
      rd_index   <= rd_index_next;
      wr_index   <= wr_index_next;
      count      <= count_next;
      call_count <= call_count_next;
    end
  end

endmodule

// File: src/brb_queue.sv
// ----------------------------------------------------------------------------
// brb_queue
// Short register queue of command records between front and back.
// ----------------------------------------------------------------------------
module brb_queue #(
  parameter int DEPTH = brb_pkg::BRB_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  brb_pkg::brb_cmd_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output brb_pkg::brb_cmd_t head
);
  import brb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  brb_cmd_t        entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [LW-1:0]   level;

  assign full       = (level == LW'(DEPTH));
  assign head_valid = (level != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

// File: src/brb_back.sv
// ----------------------------------------------------------------------------
// brb_back
// Carries out the memory access of each command and holds the result in the
// output register, with spans worked out from the post-transaction state.
// ----------------------------------------------------------------------------
module brb_back #(
  parameter int CAPACITY = brb_pkg::BRB_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  brb_pkg::brb_cmd_t          head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brb_pkg::DATA_W-1:0] read_byte,
  output logic                       ok,
  output logic [brb_pkg::CNT_W-1:0]  fill,
  output logic [brb_pkg::CNT_W-1:0]  write_span,
  output logic [brb_pkg::CNT_W-1:0]  read_span,
  output logic                       became_full,
  output logic                       left_full,
  output logic [brb_pkg::CNT_W-1:0]  call_accepted
);
  import brb_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic              rd_sel;

  logic [IW-1:0] h_rd;
  logic [IW-1:0] h_wr;
  logic [CW-1:0] h_count;
  logic [CW-1:0] wspan;
  logic [CW-1:0] rspan;

  assign pop  = head_valid && (!out_valid || out_ready);

  assign h_rd    = head.rd_index[IW-1:0];
  assign h_wr    = head.wr_index[IW-1:0];
  assign h_count = head.count[CW-1:0];

  always_comb begin
    if (h_count == CW'(CAPACITY)) begin
      wspan = '0;
    end else if (h_wr >= h_rd) begin
      wspan = CW'(CAPACITY) - CW'(h_wr);
    end else begin
      wspan = CW'(h_rd) - CW'(h_wr);
    end
    if (h_count == '0) begin
      rspan = '0;
    end else if (h_rd < h_wr) begin
      rspan = CW'(h_wr) - CW'(h_rd);
    end else begin
      rspan = CW'(CAPACITY) - CW'(h_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.mem_we) begin
        mem[head.addr[IW-1:0]] <= head.wdata;
      end
      rdata <= mem[head.addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_sel        <= head.rd_sel;
      ok            <= head.ok;
      fill          <= CNT_W'(h_count);
      write_span    <= CNT_W'(wspan);
      read_span     <= CNT_W'(rspan);
      became_full   <= head.became_full;
      left_full     <= head.left_full;
      call_accepted <= head.call_accepted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign read_byte = rd_sel ? rdata : '0;

endmodule

// File: src/brb_checker.sv
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks of the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_ring_buffer_macros.svh"

module brb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [brb_pkg::OP_W-1:0]   op,
  input logic [brb_pkg::DATA_W-1:0] data,
  input logic [brb_pkg::CNT_W-1:0]  amount,
  input logic                       last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brb_pkg::DATA_W-1:0] read_byte,
  input logic                       ok,
  input logic [brb_pkg::CNT_W-1:0]  fill,
  input logic [brb_pkg::CNT_W-1:0]  write_span,
  input logic [brb_pkg::CNT_W-1:0]  read_span,
  input logic                       became_full,
  input logic                       left_full,
  input logic [brb_pkg::CNT_W-1:0]  call_accepted
);

  // Hold a waiting input transaction.
  `BRB_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(op) && $stable(data) && $stable(amount) && $stable(last), "input changed while waiting")

  // Hold a stalled result.
  `BRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fill) && $stable(read_byte) && $stable(call_accepted), "result changed while stalled")

  // A transaction that became full leaves no write space and data to read.
  `BRB_ASSERT_NOW(a_full_spans, out_valid && became_full, ok && write_span == '0 && read_span != '0, "full result with bad spans")

  // A rejected transaction reports no byte and no full events.
  `BRB_ASSERT_NOW(a_reject_quiet, out_valid && !ok, read_byte == '0 && !became_full && !left_full, "rejected transaction reported data or event")

  // An empty buffer has nothing to read.
  `BRB_ASSERT_NOW(a_empty_span, out_valid && fill == '0, read_span == '0 && !became_full, "empty buffer with read span")

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (.*);
